### hw/rtl/cfse_pkg.sv
// shared constants and types of the can frame signal extractor
`default_nettype none
package cfse_pkg;

    // default table geometry
    localparam int MSG_SLOTS_DEF    = 16;
    localparam int SIGS_PER_MSG_DEF = 8;
    // most results one frame can give
    localparam int MAX_RES          = 8;

    // request operations carried in tuser
    localparam logic OP_DEFINE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // widths of the packed streams
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 72;

    // definition write towards the table
    typedef struct packed {
        logic        en;
        logic [7:0]  slot;
        logic [4:0]  sig;
        logic [10:0] msg_id;
        logic [3:0]  count;
        logic [14:0] layout;
        logic [63:0] scale_offset;
    } tbl_wr_t;

    // result of the shared scaling unit
    typedef struct packed {
        logic        done;
        logic        sat;
        logic [63:0] value;
    } scl_res_t;

endpackage
`default_nettype wire

### hw/rtl/cfse_table.sv
// message slot table and signal definition memory
`default_nettype none
module cfse_table
    import cfse_pkg::*;
#(
    parameter int MSG_SLOTS    = MSG_SLOTS_DEF,
    parameter int SIGS_PER_MSG = SIGS_PER_MSG_DEF,
    localparam int SLOT_W = (MSG_SLOTS > 1) ? $clog2(MSG_SLOTS) : 1,
    localparam int SIG_W  = (SIGS_PER_MSG > 1) ? $clog2(SIGS_PER_MSG) : 1,
    localparam int DEPTH  = MSG_SLOTS * SIGS_PER_MSG,
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tbl_wr_t           wr,
    input  wire logic [SLOT_W-1:0] info_addr,
    input  wire logic [IDX_W-1:0]  sig_addr,
    output logic                   info_valid,
    output logic [10:0]            info_id,
    output logic [3:0]             info_cnt,
    output logic [14:0]            sig_layout,
    output logic [63:0]            sig_so
);

    logic [MSG_SLOTS-1:0] valid_reg;
    logic [14:0]          info_mem [MSG_SLOTS];
    logic [78:0]          sig_mem  [DEPTH];
    logic [14:0]          info_rd_reg;
    logic [78:0]          sig_rd_reg;
    logic                 valid_rd_reg;
    logic [SLOT_W-1:0]    wslot;
    logic [IDX_W-1:0]     widx;

    assign wslot = wr.slot[SLOT_W-1:0];
    assign widx  = IDX_W'(int'(wslot) * SIGS_PER_MSG + int'(wr.sig[SIG_W-1:0]));

    // valid bits, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wslot] <= 1'b1;
        end
    end

    // memories with registered reads
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            info_mem[wslot] <= {wr.count, wr.msg_id};
            sig_mem[widx]   <= {wr.layout, wr.scale_offset};
        end
        info_rd_reg  <= info_mem[info_addr];
        sig_rd_reg   <= sig_mem[sig_addr];
        valid_rd_reg <= valid_reg[info_addr];
    end

    assign info_valid = valid_rd_reg;
    assign info_id    = info_rd_reg[10:0];
    assign info_cnt   = info_rd_reg[14:11];
    assign sig_layout = sig_rd_reg[78:64];
    assign sig_so     = sig_rd_reg[63:0];

endmodule
`default_nettype wire

### hw/rtl/cfse_scale.sv
// field extraction and scaling over one shared 32x32 multiplier
`default_nettype none
module cfse_scale
    import cfse_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] data,
    input  wire logic [14:0] layout,
    input  wire logic [63:0] so,
    output scl_res_t         res
);

    typedef enum logic [7:0] {
        SC_IDLE = 8'b0000_0001,
        SC_EXT  = 8'b0000_0010,
        SC_MAG  = 8'b0000_0100,
        SC_MUL0 = 8'b0000_1000,
        SC_MUL1 = 8'b0001_0000,
        SC_SUM  = 8'b0010_0000,
        SC_NEG  = 8'b0100_0000,
        SC_ADD  = 8'b1000_0000
    } sc_state_t;

    typedef enum logic [1:0] {
        CLS8  = 2'd0,
        CLS16 = 2'd1,
        CLS32 = 2'd2,
        CLS64 = 2'd3
    } cls_t;

    sc_state_t    state_reg, state_next;
    logic [63:0]  data_reg;
    logic [14:0]  lay_reg;
    logic [63:0]  so_reg;
    logic [63:0]  u_reg;
    cls_t         cls_reg;
    logic         sgn_reg;
    logic [31:0]  smag_reg;
    logic         sneg_reg;
    logic [63:0]  mag_reg;
    logic         flip_reg;
    logic [63:0]  p0_reg, p1_reg;
    logic [95:0]  prod_reg;
    logic [96:0]  sval_reg;
    logic         done_reg;
    logic         sat_reg;
    logic [63:0]  value_reg;

    logic [5:0]   start_bit;
    logic [6:0]   len;
    logic         big;
    logic [7:0]   sh;
    logic [63:0]  field;
    cls_t         cls;
    logic [63:0]  u;
    logic [63:0]  wmask;
    logic         msb;
    logic [63:0]  negu;
    logic [31:0]  mul_a;
    logic [63:0]  mul_out;
    logic [97:0]  tot;
    logic         fits;

    // field position and width class
    always_comb begin
        start_bit = lay_reg[5:0];
        len       = lay_reg[12:6];
        big       = lay_reg[14];
        sh        = big ? ({2'b00, start_bit} - 8'd7) : {2'b00, start_bit};
        field     = (data_reg >> sh) & ((64'd1 << len) - 64'd1);
        if (len <= 7'd8) begin
            cls = CLS8;
        end else if (len <= 7'd16) begin
            cls = CLS16;
        end else if (len <= 7'd32) begin
            cls = CLS32;
        end else begin
            cls = CLS64;
        end
        unique case (cls)
            CLS8:  u = {56'd0, field[7:0]};
            CLS16: u = big ? {48'd0, field[7:0], field[15:8]} : {48'd0, field[15:0]};
            CLS32: u = big ? {32'd0, field[7:0], field[15:8], field[23:16], field[31:24]}
                           : {32'd0, field[31:0]};
            CLS64: u = big ? {field[7:0], field[15:8], field[23:16], field[31:24],
                              field[39:32], field[47:40], field[55:48], field[63:56]}
                           : field;
            default: u = field;
        endcase
    end

    // sign of the class and its magnitude
    always_comb begin
        unique case (cls_reg)
            CLS8:    begin msb = u_reg[7];  wmask = 64'h0000_0000_0000_00FF; end
            CLS16:   begin msb = u_reg[15]; wmask = 64'h0000_0000_0000_FFFF; end
            CLS32:   begin msb = u_reg[31]; wmask = 64'h0000_0000_FFFF_FFFF; end
            CLS64:   begin msb = u_reg[63]; wmask = 64'hFFFF_FFFF_FFFF_FFFF; end
            default: begin msb = u_reg[63]; wmask = 64'hFFFF_FFFF_FFFF_FFFF; end
        endcase
        negu = (~u_reg + 64'd1) & wmask;
    end

    // the shared multiplier takes one half of the magnitude at a time
    assign mul_a   = (state_reg == SC_MUL1) ? mag_reg[63:32] : mag_reg[31:0];
    assign mul_out = {32'd0, mul_a} * {32'd0, smag_reg};

    // offset add and saturation
    assign tot  = {sval_reg[96], sval_reg} + {{66{so_reg[63]}}, so_reg[63:32]};
    assign fits = (tot[97:63] == '0) || (tot[97:63] == '1);

    // step sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SC_IDLE: if (start) state_next = SC_EXT;
            SC_EXT:  state_next = SC_MAG;
            SC_MAG:  state_next = SC_MUL0;
            SC_MUL0: state_next = SC_MUL1;
            SC_MUL1: state_next = SC_SUM;
            SC_SUM:  state_next = SC_NEG;
            SC_NEG:  state_next = SC_ADD;
            SC_ADD:  state_next = SC_IDLE;
            default: state_next = SC_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == SC_ADD);
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            SC_IDLE: begin
                if (start) begin
                    data_reg <= data;
                    lay_reg  <= layout;
                    so_reg   <= so;
                end
            end
            SC_EXT: begin
                u_reg    <= u;
                cls_reg  <= cls;
                sgn_reg  <= lay_reg[13];
                sneg_reg <= so_reg[31];
                smag_reg <= so_reg[31] ? (~so_reg[31:0] + 32'd1) : so_reg[31:0];
            end
            SC_MAG: begin
                mag_reg  <= (sgn_reg && msb) ? negu : u_reg;
                flip_reg <= (sgn_reg && msb) ^ sneg_reg;
            end
            SC_MUL0: p0_reg <= mul_out;
            SC_MUL1: p1_reg <= mul_out;
            SC_SUM:  prod_reg <= {32'd0, p0_reg} + {p1_reg, 32'd0};
            SC_NEG:  sval_reg <= flip_reg ? (~{1'b0, prod_reg} + 97'd1) : {1'b0, prod_reg};
            SC_ADD: begin
                sat_reg   <= !fits;
                value_reg <= fits ? tot[63:0]
                           : (tot[97] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF);
            end
            default: ;
        endcase
    end

    assign res.done  = done_reg;
    assign res.sat   = sat_reg;
    assign res.value = value_reg;

endmodule
`default_nettype wire

### hw/rtl/can_frame_signal_extractor.sv
// top level of the can frame signal extractor: request sequencer and result register
//
//  channel   dir  handshake                      contents
//  s_axis    in   s_axis_tvalid / s_axis_tready  definition write or frame decode
//  m_axis    out  m_axis_tvalid / m_axis_tready  one scaled signal per beat
//
// a definition write is taken in the idle state. a decode scans the slots, a table
// read and a compare for each, until the first match, then works its signals in turn:
// a table read, the start of the shared unit and its seven steps with the done flag.
// reset is synchronous, active low, and leaves the table empty.
// one request is worked at a time; a stalled result holds the sequencer
// until the output register frees, and the last result may wait while the next
// request is taken.
`default_nettype none
module can_frame_signal_extractor
    import cfse_pkg::*;
#(
    parameter int MSG_SLOTS    = MSG_SLOTS_DEF,
    parameter int SIGS_PER_MSG = SIGS_PER_MSG_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // msg_id, dlc, data, msg_slot, sig_index, sig_count, start_bit, bit_len,
    // is_signed, big_endian, zero fill
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // op
    input  wire logic [0:0]           s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // slot, signal_pos, value, saturated
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    output logic                      m_axis_tlast
);

    localparam int SLOT_W = (MSG_SLOTS > 1) ? $clog2(MSG_SLOTS) : 1;
    localparam int DEPTH  = MSG_SLOTS * SIGS_PER_MSG;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM    = (SIGS_PER_MSG < MAX_RES) ? SIGS_PER_MSG : MAX_RES;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b00_0001,
        ST_SRCH_RD  = 6'b00_0010,
        ST_SRCH_CMP = 6'b00_0100,
        ST_SIG_RD   = 6'b00_1000,
        ST_SIG_GO   = 6'b01_0000,
        ST_SIG_WAIT = 6'b10_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] scan_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [3:0]        k_reg;
    logic [3:0]        cnt_reg;
    logic [10:0]       id_reg;
    logic [63:0]       data_reg;
    logic              out_wait_reg;
    logic              m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic              m_last_reg;

    logic              accept;
    logic [10:0]       in_id;
    logic [3:0]        in_dlc;
    logic [63:0]       in_data;
    logic [3:0]        in_slot;
    logic [2:0]        in_sig;
    logic [3:0]        in_cnt;
    logic [63:0]       dmask;
    tbl_wr_t           wr;
    logic [IDX_W-1:0]  sig_addr;
    logic              info_valid;
    logic [10:0]       info_id;
    logic [3:0]        info_cnt;
    logic [14:0]       sig_layout;
    logic [63:0]       sig_so;
    scl_res_t          res;
    logic              out_free;
    logic              hit;

    assign in_id   = s_axis_tdata[10:0];
    assign in_dlc  = s_axis_tdata[14:11];
    assign in_data = s_axis_tdata[78:15];
    assign in_slot = s_axis_tdata[82:79];
    assign in_sig  = s_axis_tdata[85:83];
    assign in_cnt  = s_axis_tdata[89:86];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // bytes at and beyond dlc read as zero
    assign dmask = (in_dlc < 4'd8) ? ((64'd1 << {in_dlc[2:0], 3'b000}) - 64'd1) : '1;

    // definition write request
    always_comb begin
        wr.en     = accept && (s_axis_tuser[0] == OP_DEFINE)
                    && (int'(in_slot) < MSG_SLOTS) && (int'(in_sig) < SIGS_PER_MSG);
        wr.slot   = 8'(in_slot);
        wr.sig    = 5'(in_sig);
        wr.msg_id = in_id;
        wr.count  = (int'(in_cnt) > LIM) ? 4'(LIM) : in_cnt;
        wr.layout = {s_axis_tdata[104], s_axis_tdata[103], s_axis_tdata[102:96],
                     s_axis_tdata[95:90]};
        wr.scale_offset = in_data;
    end

    assign sig_addr = IDX_W'(int'(slot_reg) * SIGS_PER_MSG + int'(k_reg));
    assign hit      = info_valid && (info_id == id_reg);

    cfse_table #(
        .MSG_SLOTS    (MSG_SLOTS),
        .SIGS_PER_MSG (SIGS_PER_MSG)
    ) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr         (wr),
        .info_addr  (scan_reg),
        .sig_addr   (sig_addr),
        .info_valid (info_valid),
        .info_id    (info_id),
        .info_cnt   (info_cnt),
        .sig_layout (sig_layout),
        .sig_so     (sig_so)
    );

    cfse_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_SIG_GO),
        .data    (data_reg),
        .layout  (sig_layout),
        .so      (sig_so),
        .res     (res)
    );

    // request sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_axis_tuser[0] == OP_DECODE)) state_next = ST_SRCH_RD;
            end
            ST_SRCH_RD: state_next = ST_SRCH_CMP;
            ST_SRCH_CMP: begin
                if (hit) begin
                    state_next = (info_cnt == 4'd0) ? ST_IDLE : ST_SIG_RD;
                end else if (scan_reg == SLOT_W'(MSG_SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SIG_RD: state_next = ST_SIG_GO;
            ST_SIG_GO: state_next = ST_SIG_WAIT;
            ST_SIG_WAIT: begin
                if ((res.done || out_wait_reg) && out_free) begin
                    state_next = (k_reg + 4'd1 == cnt_reg) ? ST_IDLE : ST_SIG_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            out_wait_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SIG_WAIT && (res.done || out_wait_reg)) begin
                out_wait_reg <= !out_free;
            end
            if (state_reg == ST_SIG_WAIT && (res.done || out_wait_reg) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request payload, scan position and output register
    always_ff @(posedge aclk) begin
        if (accept) begin
            id_reg   <= in_id;
            data_reg <= in_data & dmask;
            scan_reg <= '0;
        end
        if (state_reg == ST_SRCH_CMP) begin
            if (hit) begin
                slot_reg <= scan_reg;
                cnt_reg  <= info_cnt;
                k_reg    <= 4'd0;
            end else begin
                scan_reg <= scan_reg + SLOT_W'(1);
            end
        end
        if (state_reg == ST_SIG_WAIT && (res.done || out_wait_reg) && out_free) begin
            m_data_reg <= {res.sat, res.value, k_reg[2:0], 4'(slot_reg)};
            m_last_reg <= (k_reg + 4'd1 == cnt_reg);
            k_reg      <= k_reg + 4'd1;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule
`default_nettype wire

### dv/tb.sv
// testbench of the can frame signal extractor: directed and random definitions and frames checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import cfse_pkg::*;

    typedef struct packed {
        logic [3:0]  slot;
        logic [2:0]  pos;
        logic [63:0] value;
        logic        sat;
        logic        last;
    } sig_res_t;

    typedef struct packed {
        logic        op;
        logic [10:0] msg_id;
        logic [3:0]  dlc;
        logic [63:0] data;
        logic [3:0]  msg_slot;
        logic [2:0]  sig_index;
        logic [3:0]  sig_count;
        logic [5:0]  start_bit;
        logic [6:0]  bit_len;
        logic        is_signed;
        logic        big_endian;
    } frame_req_t;

    localparam int REQ_W = $bits(frame_req_t);

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [0:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;

    can_frame_signal_extractor dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predictor state
    logic        tbl_valid [16];
    logic [10:0] tbl_id [16];
    logic [3:0]  tbl_count [16];
    logic [14:0] tbl_layout [128];
    logic [63:0] tbl_so [128];
    logic        tbl_written [128];

    frame_req_t req_q[$];
    sig_res_t   signals_due[$];
    int errors = 0;
    int pushed = 0;
    bit stim_done = 0;
    bit hold_off = 0;

    task automatic report(input string what, input sig_res_t got, input sig_res_t want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    function automatic sig_res_t scale_signal(input logic [63:0] d, input logic [14:0] lay,
                                              input logic [63:0] so, input int s, input int k);
        sig_res_t r;
        logic [5:0] st;
        logic [6:0] len;
        logic [7:0] sh;
        logic [63:0] f, u, wm;
        int w;
        logic signed [127:0] raw, prod, sum;
        logic signed [31:0] sc, ofs;
        st = lay[5:0];
        len = lay[12:6];
        sh = lay[14] ? 8'(st - 7) : {2'b0, st};
        f = sh < 64 ? d >> sh : 64'd0;
        if (len < 64) f &= (64'd1 << len) - 1;
        w = len <= 8 ? 8 : len <= 16 ? 16 : len <= 32 ? 32 : 64;
        wm = w == 64 ? '1 : (64'd1 << w) - 1;
        u = f & wm;
        if (lay[14] && w > 8) begin
            logic [63:0] t;
            t = 0;
            for (int b = 0; b < w / 8; b++) t[8*(w/8-1-b) +: 8] = u[8*b +: 8];
            u = t;
        end
        raw = {64'd0, u};
        if (lay[13] && u[w-1]) raw = raw - (128'sd1 <<< w);
        sc = so[31:0];
        ofs = so[63:32];
        prod = raw * 128'(sc);
        sum = prod + 128'(ofs);
        r.slot = 4'(s);
        r.pos = 3'(k);
        if (sum > 128'sh7FFFFFFFFFFFFFFF) begin
            r.value = 64'h7FFFFFFFFFFFFFFF; r.sat = 1;
        end else if (sum < -128'sh8000000000000000) begin
            r.value = 64'h8000000000000000; r.sat = 1;
        end else begin
            r.value = sum[63:0]; r.sat = 0;
        end
        r.last = 0;
        return r;
    endfunction

    // apply one request to the predictor
    task automatic predict(input frame_req_t q);
        int s, cnt;
        sig_res_t r;
        logic [63:0] d;
        if (q.op == OP_DEFINE) begin
            s = q.msg_slot;
            tbl_valid[s] = 1;
            tbl_id[s] = q.msg_id;
            tbl_count[s] = q.sig_count > 8 ? 4'd8 : q.sig_count;
            tbl_layout[s*8+q.sig_index] = {q.big_endian, q.is_signed, q.bit_len, q.start_bit};
            tbl_so[s*8+q.sig_index] = q.data;
            tbl_written[s*8+q.sig_index] = 1;
            return;
        end
        d = q.data;
        if (q.dlc < 8) d &= (64'd1 << (8 * q.dlc)) - 1;
        s = -1;
        for (int i = 15; i >= 0; i--) if (tbl_valid[i] && tbl_id[i] == q.msg_id) s = i;
        if (s < 0) return;
        cnt = tbl_count[s];
        for (int k = 0; k < cnt; k++) begin
            r = scale_signal(d, tbl_layout[s*8+k], tbl_so[s*8+k], s, k);
            r.last = (k + 1 == cnt);
            signals_due = {signals_due, r};
        end
    endtask

    // a decode is safe when every counted definition has been written
    function automatic bit decode_safe(input logic [10:0] id);
        for (int i = 0; i < 16; i++)
            if (tbl_valid[i] && tbl_id[i] == id) begin
                for (int k = 0; k < tbl_count[i]; k++) if (!tbl_written[i*8+k]) return 0;
                return 1;
            end
        return 1;
    endfunction

    // handshake seen at the rising edge
    logic s_axis_tready_q = 0;
    always @(posedge aclk) s_axis_tready_q <= s_axis_tvalid && s_axis_tready;

    // driver
    int gap = 0;
    frame_req_t cur;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready_q) begin
                predict(cur);
                void'(req_q.pop_front());
                gap = $urandom_range(0, 12);
                if ($urandom_range(0, 3) == 0) gap = 0;
            end
            if (s_axis_tvalid && !s_axis_tready_q) begin
            end else if (gap > 0 || hold_off || req_q.size() == 0) begin
                if (gap > 0) gap--;
                s_axis_tvalid <= 0;
            end else begin
                cur = req_q[0];
                s_axis_tvalid <= 1;
                s_axis_tuser <= cur.op;
                s_axis_tdata <= S_TDATA_W'({cur.big_endian, cur.is_signed, cur.bit_len,
                                            cur.start_bit, cur.sig_count, cur.sig_index,
                                            cur.msg_slot, cur.data, cur.dlc, cur.msg_id});
            end
        end
    end

    // monitor
    int stall = 0;
    always @(posedge aclk) begin
        sig_res_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[3:0], m_axis_tdata[6:4], m_axis_tdata[70:7],
                   m_axis_tdata[71], m_axis_tlast};
            if (signals_due.size() == 0) begin
                report("unexpected result", got, got);
            end else begin
                want = signals_due.pop_front();
                if (got.slot != want.slot) report("slot", got, want);
                if (got.pos != want.pos) report("signal_pos", got, want);
                if (got.value != want.value) report("value", got, want);
                if (got.sat != want.sat) report("saturated", got, want);
                if (got.last != want.last) report("last", got, want);
            end
        end
    end
    always @(negedge aclk) begin
        if (m_axis_tvalid && m_axis_tready) stall = $urandom_range(0, 12);
        if ($urandom_range(0, 2) == 0 && stall > 4) stall = 0;
        if (stall > 0) begin
            stall--;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= 1;
        end
    end

    // stimulus shadow table, tracks what has been queued
    logic        sh_valid [16];
    logic [10:0] sh_id [16];
    logic [3:0]  sh_cnt [16];
    logic        sh_wr [128];
    logic [10:0] ids [4] = '{11'h000, 11'h7FF, 11'h123, 11'h456};

    function automatic bit shadow_safe(input logic [10:0] id);
        for (int i = 0; i < 16; i++)
            if (sh_valid[i] && sh_id[i] == id) begin
                for (int k = 0; k < sh_cnt[i]; k++) if (!sh_wr[i*8+k]) return 0;
                return 1;
            end
        return 1;
    endfunction

    task automatic push_def(input int s, input int k, input int cnt, input logic [10:0] id,
                            input logic [63:0] so, input int st, input int len,
                            input bit sg, input bit be);
        frame_req_t q;
        q = '0;
        q.op = OP_DEFINE; q.msg_id = id; q.msg_slot = 4'(s); q.sig_index = 3'(k);
        q.sig_count = 4'(cnt); q.data = so; q.start_bit = 6'(st); q.bit_len = 7'(len);
        q.is_signed = sg; q.big_endian = be;
        q.dlc = 4'($urandom); q.data = so;
        sh_valid[s] = 1; sh_id[s] = id; sh_cnt[s] = cnt > 8 ? 4'd8 : 4'(cnt);
        sh_wr[s*8+k] = 1;
        req_q = {req_q, q};
        pushed++;
    endtask

    task automatic push_frame(input logic [10:0] id, input int dlc, input logic [63:0] d);
        frame_req_t q;
        q = frame_req_t'(REQ_W'({$urandom, $urandom, $urandom, $urandom}));
        q.op = OP_DECODE; q.msg_id = id; q.dlc = 4'(dlc); q.data = d;
        if (shadow_safe(id)) begin
            req_q = {req_q, q};
            pushed++;
        end
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    initial begin
        int s, cnt, len;
        logic [63:0] so;
        for (int i = 0; i < 16; i++) begin tbl_valid[i] = 0; sh_valid[i] = 0; end
        for (int i = 0; i < 128; i++) begin tbl_written[i] = 0; sh_wr[i] = 0; end
        repeat (4) @(posedge aclk);
        @(negedge aclk) aresetn = 1;

        // directed: unknown id, extremes of length and order, saturation, empty slot
        push_frame(11'h7FF, 8, '1);
        push_def(0, 0, 4, 11'h7FF, {32'h0, 32'h0001_0000}, 0, 64, 0, 0);
        push_def(0, 1, 4, 11'h7FF, {32'h8000_0000, 32'h7FFF_FFFF}, 63, 64, 1, 1);
        push_def(0, 2, 4, 11'h7FF, {32'h7FFF_FFFF, 32'h8000_0000}, 3, 1, 1, 1);
        push_def(0, 3, 4, 11'h7FF, {32'hFFFF_FFFF, 32'hFFFF_FFFF}, 7, 16, 1, 1);
        push_frame(11'h7FF, 8, '1);
        push_frame(11'h7FF, 15, 64'h8000_0000_0000_0001);
        push_frame(11'h7FF, 0, '1);
        push_def(1, 0, 0, 11'h000, 64'h1, 0, 8, 0, 0);
        push_frame(11'h000, 3, rnd64());
        push_def(2, 7, 15, 11'h7FF, rnd64(), 5, 32, 1, 0);
        push_def(15, 0, 1, 11'h123, {32'h0, 32'h8000_0000}, 40, 33, 1, 0);
        push_frame(11'h123, 8, 64'hFFFF_FF00_0000_0000);
        push_frame(11'h7FF, 8, rnd64());

        // random: definitions over few ids, many frames
        for (int n = 0; pushed < 230; n++) begin
            if (n == 60) begin
                wait (req_q.size() == 0 && signals_due.size() == 0);
                hold_off = 1;
                repeat (400) @(posedge aclk);
                hold_off = 0;
            end
            if ($urandom_range(0, 2) == 0) begin
                s = $urandom_range(0, 15);
                cnt = $urandom_range(0, 15);
                len = $urandom_range(0, 3) == 0 ? $urandom_range(33, 64) : $urandom_range(1, 32);
                so = rnd64();
                if ($urandom_range(0, 1)) so = {{16{so[63]}}, so[47:16], {16{so[31]}}, so[15:0]};
                push_def(s, $urandom_range(0, 7), cnt, ids[$urandom_range(0, 3)], so,
                         $urandom_range(0, 63), len, 1'($urandom), 1'($urandom));
                // fill missing definitions of the slot, each at random, so that its frames may be decoded
                for (int k = 0; k < sh_cnt[s]; k++)
                    if (!sh_wr[s*8+k] && $urandom_range(0, 3) != 0)
                        push_def(s, k, cnt, sh_id[s], rnd64(), $urandom_range(0, 63),
                                 $urandom_range(1, 64), 1'($urandom), 1'($urandom));
            end else begin
                push_frame($urandom_range(0, 7) == 0 ? 11'($urandom) : ids[$urandom_range(0, 3)],
                           $urandom_range(0, 15), rnd64());
            end
        end
        stim_done = 1;
    end

    // end of run
    initial begin
        wait (stim_done);
        wait (req_q.size() == 0 && !s_axis_tvalid && signals_due.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0 && signals_due.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
hw/rtl/cfse_pkg.sv
hw/rtl/cfse_table.sv
hw/rtl/cfse_scale.sv
hw/rtl/can_frame_signal_extractor.sv
dv/tb.sv
